>>> hw/rtl/sts_pkg.sv
// Shared types and constants for the steering track selector.
// Holds the transaction structs, register indexes and the shared divider interface.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

	localparam int MAX_TRACKS = 32;
	localparam int DIV_NUM_W  = 14;
	localparam int DIV_DEN_W  = 8;
	localparam int DIV_CNT_W  = 4;

	localparam logic [5:0] MAX_TRACKS_V    = 6'(MAX_TRACKS);
	localparam logic [5:0] MIN_ZONED_TRACKS = 6'd3;
	localparam logic [7:0] ZONE_SPAN       = 8'd255;
	localparam logic [13:0] CENTRE_OFS     = 14'd127;
	localparam logic signed [15:0] HYST_UP = 16'sd125;
	localparam logic signed [15:0] HYST_DN = 16'sd129;
	localparam logic signed [7:0] HAND_EDGE = 8'sd42;
	localparam logic [7:0] THR_LO          = 8'h55;
	localparam logic [7:0] THR_HI          = 8'hAA;
	localparam logic [6:0] SPRING_MIN      = 7'd30;
	localparam logic [6:0] SPRING_MAX      = 7'd80;
	localparam logic [7:0] SPRING_STEP     = 8'd5;
	localparam logic [7:0] GAIN_DIV        = 8'd127;
	localparam logic [13:0] GAIN_ROUND     = 14'd63;
	localparam logic [6:0] GAIN_MIN        = 7'd10;
	localparam logic [6:0] GAIN_MAX        = 7'd100;

	localparam logic OP_ENTER = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [1:0] FRAME_LEFT  = 2'd0;
	localparam logic [1:0] FRAME_MID   = 2'd1;
	localparam logic [1:0] FRAME_RIGHT = 2'd2;

	localparam logic [1:0] CFG_TRACK_COUNT    = 2'd0;
	localparam logic [1:0] CFG_ANALOG_MODE    = 2'd1;
	localparam logic [1:0] CFG_HAPTIC_ENABLE  = 2'd2;
	localparam logic [1:0] CFG_CENTERING_BASE = 2'd3;

	typedef struct packed {
		logic [5:0] track_count;
		logic       analog_mode;
		logic       haptic_enable;
		logic [6:0] centering_base;
	} cfg_t;

	typedef struct packed {
		logic              operation;
		logic signed [7:0] wheel_position;
		logic              press_left;
		logic              press_right;
	} in_item_t;

	typedef struct packed {
		logic [4:0] selected_track;
		logic [1:0] hand_frame;
		logic [6:0] spring_level;
		logic       detent_active;
		logic       detent_left;
		logic [6:0] detent_pull;
		logic       stop_request;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/sts_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on sts_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module sts_div import sts_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] acc_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W+1:0] trial;

	assign trial = {1'b0, rem_q, acc_q[DIV_NUM_W-1]} - {2'b00, req.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				rem_q  <= '0;
				acc_q  <= req.num;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!trial[DIV_DEN_W+1]) begin
					rem_q <= trial[DIV_DEN_W-1:0];
					acc_q <= {acc_q[DIV_NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DIV_DEN_W-2:0], acc_q[DIV_NUM_W-1]};
					acc_q <= {acc_q[DIV_NUM_W-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - DIV_CNT_W'(1);
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = acc_q;

endmodule

`default_nettype wire

>>> hw/rtl/sts_ctrl.sv
// Sequencer and datapath: zone mapping, hysteresis, zone centre and detent gain.
// Drives the shared divider sts_div; uses sts_pkg types and constants.
`timescale 1ns / 1ps
`default_nettype none

module sts_ctrl import sts_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     in_valid,
	input  wire in_item_t in_item,
	output logic          ready,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_item_t     out_item
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_LOAD = 8'b0000_0010,
		ST_ZONE = 8'b0000_0100,
		ST_BND  = 8'b0000_1000,
		ST_CTR  = 8'b0001_0000,
		ST_FIN  = 8'b0010_0000,
		ST_GAIN = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic              go_q;
	logic              op_q;
	logic signed [7:0] w_q;
	logic              pl_q;
	logic              pr_q;
	logic [5:0]        n_q;
	logic [6:0]        spring_q;
	logic [4:0]        cursor_q;
	logic [4:0]        mapped_q;
	logic              up_q;
	logic signed [7:0] target_q;
	logic signed [7:0] applied_q;
	logic [4:0]        sel_q;
	logic [1:0]        hand_q;
	logic              active_q;
	logic              left_q;
	logic [6:0]        gain_q;
	logic              stop_q;
	logic              out_valid_q;
	out_item_t         out_q;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic [5:0]        n_eff;
	logic [6:0]        base_c;
	logic [7:0]        boost;
	logic [8:0]        spring_sum;
	logic [6:0]        spring_eff;
	logic [5:0]        n_m1;
	logic signed [7:0] w_clamp;
	logic [8:0]        zone_sum;
	logic [13:0]       zone_num;
	logic [5:0]        bnd_c;
	logic [13:0]       bnd_num;
	logic [4:0]        t_c;
	logic [13:0]       ctr_num;
	logic [7:0]        ctr_den;
	logic [6:0]        ta;
	logic [13:0]       gain_num;
	logic [4:0]        c_sat;
	logic [4:0]        c_step;
	logic [7:0]        w_off;
	logic [4:0]        mapped_next;
	logic signed [15:0] ws;
	logic signed [15:0] qs;
	logic              up_pass;
	logic              dn_pass;
	logic [13:0]       ctr_d;
	logic signed [7:0] ctr_v;
	logic [1:0]        ctr_hand;
	logic [6:0]        gain_c;
	logic              zoned;
	logic              few;

	always_comb begin
		n_eff      = (cfg.track_count > MAX_TRACKS_V) ? MAX_TRACKS_V : cfg.track_count;
		base_c     = (cfg.centering_base < SPRING_MIN) ? SPRING_MIN : cfg.centering_base;
		boost      = (n_eff > MIN_ZONED_TRACKS) ?
			8'({2'b00, n_eff - MIN_ZONED_TRACKS} * SPRING_STEP) : 8'd0;
		spring_sum = {2'b00, base_c} + {1'b0, boost};
		spring_eff = (spring_sum > {2'b00, SPRING_MAX}) ? SPRING_MAX : spring_sum[6:0];

		n_m1     = n_q - 6'd1;
		zoned    = n_q >= MIN_ZONED_TRACKS;
		few      = n_q <= 6'd1;
		w_clamp  = (w_q == -8'sd128) ? -8'sd127 : w_q;
		zone_sum = {w_clamp[7], w_clamp} + 9'd127;
		zone_num = 14'({6'd0, zone_sum[7:0]} * {8'd0, n_q});
		bnd_c    = up_q ? ({1'b0, cursor_q} + 6'd1) : {1'b0, cursor_q};
		bnd_num  = 14'({8'd0, bnd_c} * {6'd0, ZONE_SPAN});
		t_c      = ({1'b0, cursor_q} > n_m1) ? n_m1[4:0] : cursor_q;
		ctr_num  = 14'({8'd0, t_c, 1'b1} * {6'd0, ZONE_SPAN});
		ctr_den  = {1'b0, n_q, 1'b0};
		ta       = target_q[7] ? 7'(-target_q) : target_q[6:0];
		gain_num = 14'({7'd0, spring_q} * {7'd0, ta}) + GAIN_ROUND;

		c_sat = ({1'b0, cursor_q} > n_m1) ? n_m1[4:0] : cursor_q;
		if (pl_q) begin
			c_step = (c_sat == 5'd0) ? n_m1[4:0] : c_sat - 5'd1;
		end else if (pr_q) begin
			c_step = ({1'b0, c_sat} + 6'd1 >= n_q) ? 5'd0 : c_sat + 5'd1;
		end else begin
			c_step = c_sat;
		end
		w_off = w_q ^ 8'h80;

		mapped_next = (div_rsp.quo >= {8'd0, n_q}) ? n_m1[4:0] : div_rsp.quo[4:0];
		ws      = 16'(w_q);
		qs      = signed'({2'b00, div_rsp.quo});
		up_pass = ws >= (qs - HYST_UP);
		dn_pass = ws <= (qs - HYST_DN);
		ctr_d   = div_rsp.quo - CENTRE_OFS;
		ctr_v   = signed'(ctr_d[7:0]);
		if (ctr_v < -HAND_EDGE) begin
			ctr_hand = FRAME_LEFT;
		end else if (ctr_v <= HAND_EDGE) begin
			ctr_hand = FRAME_MID;
		end else begin
			ctr_hand = FRAME_RIGHT;
		end
		if (div_rsp.quo < {7'd0, GAIN_MIN}) begin
			gain_c = GAIN_MIN;
		end else if (div_rsp.quo > {7'd0, GAIN_MAX}) begin
			gain_c = GAIN_MAX;
		end else begin
			gain_c = div_rsp.quo[6:0];
		end
	end

	always_comb begin
		div_req.start = go_q;
		unique case (state_q)
			ST_BND: begin
				div_req.num = bnd_num;
				div_req.den = {2'b00, n_q};
			end
			ST_CTR: begin
				div_req.num = ctr_num;
				div_req.den = ctr_den;
			end
			ST_GAIN: begin
				div_req.num = gain_num;
				div_req.den = GAIN_DIV;
			end
			default: begin
				div_req.num = zone_num;
				div_req.den = ZONE_SPAN;
			end
		endcase
	end

	sts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			op_q        <= OP_ENTER;
			w_q         <= '0;
			pl_q        <= 1'b0;
			pr_q        <= 1'b0;
			n_q         <= '0;
			spring_q    <= '0;
			cursor_q    <= '0;
			mapped_q    <= '0;
			up_q        <= 1'b0;
			target_q    <= '0;
			applied_q   <= '0;
			sel_q       <= '0;
			hand_q      <= FRAME_LEFT;
			active_q    <= 1'b0;
			left_q      <= 1'b0;
			gain_q      <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q     <= in_item.operation;
						w_q      <= in_item.wheel_position;
						pl_q     <= in_item.press_left;
						pr_q     <= in_item.press_right;
						n_q      <= n_eff;
						spring_q <= spring_eff;
						state_q  <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					active_q <= 1'b0;
					left_q   <= 1'b0;
					gain_q   <= '0;
					stop_q   <= 1'b0;
					if (op_q == OP_ENTER) begin
						if (few) begin
							cursor_q  <= '0;
							applied_q <= '0;
							sel_q     <= '0;
							hand_q    <= FRAME_LEFT;
							state_q   <= ST_DONE;
						end else begin
							go_q    <= 1'b1;
							state_q <= ST_ZONE;
						end
					end else if (!zoned) begin
						if (w_off <= THR_LO) begin
							sel_q  <= 5'd0;
							hand_q <= FRAME_LEFT;
						end else if (w_off <= THR_HI) begin
							sel_q  <= 5'd1;
							hand_q <= FRAME_MID;
						end else begin
							sel_q  <= 5'd2;
							hand_q <= FRAME_RIGHT;
						end
						if (few) begin
							target_q <= '0;
							state_q  <= ST_FIN;
						end else begin
							go_q    <= 1'b1;
							state_q <= ST_CTR;
						end
					end else if (cfg.analog_mode) begin
						cursor_q <= c_sat;
						go_q     <= 1'b1;
						state_q  <= ST_ZONE;
					end else begin
						cursor_q <= c_step;
						go_q     <= 1'b1;
						state_q  <= ST_CTR;
					end
				end
				ST_ZONE: begin
					if (div_rsp.done) begin
						if (op_q == OP_ENTER) begin
							cursor_q  <= mapped_next;
							applied_q <= '0;
							sel_q     <= mapped_next;
							hand_q    <= FRAME_LEFT;
							state_q   <= ST_DONE;
						end else if (mapped_next != cursor_q) begin
							mapped_q <= mapped_next;
							up_q     <= mapped_next > cursor_q;
							go_q     <= 1'b1;
							state_q  <= ST_BND;
						end else begin
							go_q    <= 1'b1;
							state_q <= ST_CTR;
						end
					end else begin
						go_q <= 1'b0;
					end
				end
				ST_BND: begin
					if (div_rsp.done) begin
						if (up_q ? up_pass : dn_pass) begin
							cursor_q <= mapped_q;
						end
						go_q    <= 1'b1;
						state_q <= ST_CTR;
					end else begin
						go_q <= 1'b0;
					end
				end
				ST_CTR: begin
					if (div_rsp.done) begin
						target_q <= ctr_v;
						if (zoned) begin
							sel_q  <= cursor_q;
							hand_q <= ctr_hand;
						end
						state_q <= ST_FIN;
					end else begin
						go_q <= 1'b0;
					end
				end
				ST_FIN: begin
					if (cfg.haptic_enable && (n_q != 6'd0)) begin
						if (target_q == 8'sd0) begin
							stop_q    <= applied_q != 8'sd0;
							applied_q <= '0;
							state_q   <= ST_DONE;
						end else begin
							go_q    <= 1'b1;
							state_q <= ST_GAIN;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_GAIN: begin
					if (div_rsp.done) begin
						gain_q    <= gain_c;
						active_q  <= 1'b1;
						left_q    <= target_q[7];
						applied_q <= target_q;
						state_q   <= ST_DONE;
					end else begin
						go_q <= 1'b0;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q.selected_track <= sel_q;
						out_q.hand_frame     <= hand_q;
						out_q.spring_level   <= spring_q;
						out_q.detent_active  <= active_q;
						out_q.detent_left    <= left_q;
						out_q.detent_pull    <= gain_q;
						out_q.stop_request   <= stop_q;
						out_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ready     = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/steering_track_selector_with_detent.sv
// Sequence: an enter with at most one track skips the divider; an analog tick past a zone
// edge with detent runs up to four divisions on the shared one-bit-per-cycle divider.
// Flow: one transaction at a time, the next taken the cycle after the result is registered;
// a stalled result holds the next one in the sequencer.
// Reset: asynchronous, active low; cursor and detent target clear, registers take defaults.
// Depends on sts_pkg, sts_ctrl and sts_div.
`timescale 1ns / 1ps
`default_nettype none

module steering_track_selector_with_detent import sts_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [6:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_item,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_item
);

	cfg_t cfg_q;
	logic ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_count    <= 6'd3;
			cfg_q.analog_mode    <= 1'b1;
			cfg_q.haptic_enable  <= 1'b0;
			cfg_q.centering_base <= 7'd30;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRACK_COUNT:    cfg_q.track_count    <= cfg_data[5:0];
				CFG_ANALOG_MODE:    cfg_q.analog_mode    <= cfg_data[0];
				CFG_HAPTIC_ENABLE:  cfg_q.haptic_enable  <= cfg_data[0];
				CFG_CENTERING_BASE: cfg_q.centering_base <= cfg_data;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	sts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.ready     (ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	assign in_stall = !ready;

endmodule

`default_nettype wire
